FILE: rtl/hash_insert_chaining_with_replace_unit_assert.svh
// assertion macros for the hash insert unit
`ifndef HASH_INSERT_CHAINING_WITH_REPLACE_UNIT_ASSERT_SVH
`define HASH_INSERT_CHAINING_WITH_REPLACE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define HIC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash unit check failed");

`define HIC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash unit check failed");

`else

`define HIC_ASSERT_IMP(label, clk, rst, ante, cons)

`define HIC_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/hic_pkg.sv
// shared types and constants for the hash insert unit
package hic_pkg;

  localparam int SLOTS     = 16;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 64;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int LINK_W    = IDX_W + 1;
  localparam int STAT_W    = 2;
  localparam int MOD_STEP  = 4;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_READ     = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_HASH_NEW,
    S_HASH_NEW_WAIT,
    S_FETCH,
    S_DECIDE,
    S_HASH_OLD,
    S_HASH_OLD_WAIT,
    S_WALK,
    S_WALK_WAIT,
    S_PROBE_CH,
    S_CH_WRITE,
    S_CH_LINK,
    S_PROBE_EV,
    S_EV_MOVE,
    S_EV_RELINK,
    S_EV_HOME,
    S_DONE_READ,
    S_DONE_HOME,
    S_DONE_PROBE,
    S_DONE_FULL
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_HOME,
    WR_TAIL,
    WR_LINK,
    WR_MOVE,
    WR_RELINK
  } wr_t;

  typedef enum logic [1:0] {
    RES_READ,
    RES_HOME,
    RES_PROBE,
    RES_FULL
  } res_t;

  typedef struct packed {
    logic load;
    logic hash_start;
    logic hash_held;
    logic cur_from_hash;
    logic hold;
    logic walk_init;
    logic walk_step;
    logic probe_init;
    logic probe_step;
    wr_t  wr;
    logic res_load;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic home_used;
    logic hash_busy;
    logic home_match;
    logic walk_more;
    logic probe_free;
    logic probe_last;
  } sts_t;

endpackage

FILE: rtl/hash_insert_chaining_with_replace_unit.sv
// top level of the hash table insert unit with chaining and replacement
// one request at a time; a read goes through fetch and decide before its result is loaded
// an insert to a free home writes it after hashing the key; otherwise the old record's key is
// hashed too, then the chain is walked one step at a time and slots are probed one by one
// a new request is taken while the previous result waits in the output register
// synchronous reset clears the used marks at once; no clearing pass
module hash_insert_chaining_with_replace_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         action,
  input  logic [hic_pkg::KEY_W-1:0]    key,
  input  logic [hic_pkg::PAY_W-1:0]    payload,
  input  logic [hic_pkg::IDX_W-1:0]    read_slot,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [hic_pkg::STAT_W-1:0]   status,
  output logic [hic_pkg::IDX_W-1:0]    slot_index,
  output logic                         slot_used,
  output logic [hic_pkg::KEY_W-1:0]    slot_key_out,
  output logic [hic_pkg::PAY_W-1:0]    slot_payload_out,
  output logic [hic_pkg::LINK_W-1:0]   prev_link,
  output logic [hic_pkg::LINK_W-1:0]   next_link
);
  import hic_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  hic_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .action          (action),
    .key             (key),
    .payload         (payload),
    .read_slot       (read_slot),
    .status          (status),
    .slot_index      (slot_index),
    .slot_used       (slot_used),
    .slot_key_out    (slot_key_out),
    .slot_payload_out(slot_payload_out),
    .prev_link       (prev_link),
    .next_link       (next_link)
  );

endmodule

FILE: rtl/hic_mod.sv
// remainder of a key by the slot count: weighted nibble fold, then compare and subtract
module hic_mod (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [hic_pkg::KEY_W-1:0]       value,
  output logic                            busy,
  output logic [hic_pkg::IDX_W-1:0]       rem
);
  import hic_pkg::*;

  localparam int Chunks = KEY_W / MOD_STEP;
  localparam int QW     = $clog2(Chunks) + MOD_STEP;
  localparam int Sub    = (QW + 1) / 2;
  localparam int AW     = IDX_W + 2 * Sub + 1;

  function automatic int fold_weight(input int pos);
    int w;
    w = 1 % SLOTS;
    for (int n = 0; n < pos; n++) begin
      w = (w * (1 << MOD_STEP)) % SLOTS;
    end
    return w;
  endfunction

  logic [AW-1:0] term [Chunks];
  logic [AW-1:0] fold;
  logic [AW-1:0] acc;
  logic [AW-1:0] acc_next;
  logic [AW-1:0] t;
  logic [AW-1:0] d;
  logic          phase;

  for (genvar g = 0; g < Chunks; g++) begin : g_term
    localparam logic [AW-1:0] Weight = AW'(fold_weight(g));
    assign term[g] = AW'(value[g*MOD_STEP +: MOD_STEP]) * Weight;
  end

  always_comb begin
    fold = '0;
    for (int i = 0; i < Chunks; i++) begin
      fold = fold + term[i];
    end
  end

  always_comb begin
    t = acc;
    d = '0;
    for (int i = 0; i < Sub; i++) begin
      d = phase ? (AW'(SLOTS) << (Sub - 1 - i)) : (AW'(SLOTS) << (2 * Sub - 1 - i));
      if (t >= d) begin
        t = t - d;
      end
    end
    acc_next = t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (busy) begin
      phase <= 1'b1;
      if (phase) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= fold;
    end else if (busy) begin
      acc <= acc_next;
    end
  end

  assign rem = acc[IDX_W-1:0];

endmodule

FILE: rtl/hic_dp.sv
// datapath: slot memories, used marks, walk and probe pointers, result register
module hic_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  hic_pkg::cmd_t                cmd,
  output hic_pkg::sts_t                sts,
  input  logic                         action,
  input  logic [hic_pkg::KEY_W-1:0]    key,
  input  logic [hic_pkg::PAY_W-1:0]    payload,
  input  logic [hic_pkg::IDX_W-1:0]    read_slot,
  output logic [hic_pkg::STAT_W-1:0]   status,
  output logic [hic_pkg::IDX_W-1:0]    slot_index,
  output logic                         slot_used,
  output logic [hic_pkg::KEY_W-1:0]    slot_key_out,
  output logic [hic_pkg::PAY_W-1:0]    slot_payload_out,
  output logic [hic_pkg::LINK_W-1:0]   prev_link,
  output logic [hic_pkg::LINK_W-1:0]   next_link
);
  import hic_pkg::*;

  localparam int Slots = SLOTS;
  localparam int IW = $clog2(Slots);
  localparam int LW = IW + 1;
  localparam logic [LW-1:0] NoLink = LW'(Slots);

  logic [KEY_W-1:0] key_mem [Slots];
  logic [PAY_W-1:0] pay_mem [Slots];
  logic [LW-1:0]    prev_mem [Slots];
  logic [LW-1:0]    next_mem [Slots];
  logic [Slots-1:0] used;

  logic [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0] rd_pay;
  logic [LW-1:0]    rd_prev;
  logic [LW-1:0]    rd_next;

  logic             is_read;
  logic             oob;
  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] pay_r;
  logic [IW-1:0]    cur;
  logic [IW-1:0]    r;
  logic [IW-1:0]    cnt;
  logic [IW:0]      steps;
  logic [KEY_W-1:0] hkey;
  logic [PAY_W-1:0] hpay;
  logic [LW-1:0]    hprev;
  logic [LW-1:0]    hnext;

  logic             rd_used;
  logic [IW-1:0]    cur_wrap;
  logic [IW-1:0]    r_wrap;

  logic             hash_busy;
  logic [IW-1:0]    hash_rem;
  logic [KEY_W-1:0] hash_val;

  logic             kp_we;
  logic [IW-1:0]    kp_wa;
  logic [KEY_W-1:0] k_wd;
  logic [PAY_W-1:0] p_wd;
  logic             pv_we;
  logic [IW-1:0]    pv_wa;
  logic [LW-1:0]    pv_wd;
  logic             nx_we;
  logic [IW-1:0]    nx_wa;
  logic [LW-1:0]    nx_wd;

  assign hash_val = cmd.hash_held ? hkey : key_r;

  hic_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.hash_start),
    .value(hash_val),
    .busy (hash_busy),
    .rem  (hash_rem)
  );

  assign rd_used  = used[cur] && !oob;
  assign cur_wrap = (cur == IW'(Slots - 1)) ? '0 : cur + IW'(1);
  assign r_wrap   = (r == IW'(Slots - 1)) ? '0 : r + IW'(1);

  always_comb begin
    sts.is_read    = is_read;
    sts.home_used  = used[cur];
    sts.hash_busy  = hash_busy;
    sts.home_match = (hash_rem == cur);
    sts.walk_more  = (rd_next < NoLink) && (steps < (IW + 1)'(Slots));
    sts.probe_free = !used[r];
    sts.probe_last = (cnt == IW'(1));
  end

  // request registers and pointers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_read <= (action == ACT_READ);
      key_r   <= key;
      pay_r   <= payload;
      cur     <= IW'(read_slot);
      oob     <= (32'(read_slot) >= 32'(Slots));
    end else if (cmd.cur_from_hash) begin
      cur <= hash_rem;
      oob <= 1'b0;
    end else if (cmd.walk_step) begin
      cur <= rd_next[IW-1:0];
    end
    if (cmd.walk_init) begin
      steps <= '0;
    end else if (cmd.walk_step) begin
      steps <= steps + (IW + 1)'(1);
    end
    if (cmd.probe_init) begin
      r   <= cur_wrap;
      cnt <= IW'(Slots - 1);
    end else if (cmd.probe_step) begin
      r   <= r_wrap;
      cnt <= cnt - IW'(1);
    end
    if (cmd.hold) begin
      hkey  <= rd_key;
      hpay  <= rd_pay;
      hprev <= rd_prev;
      hnext <= rd_next;
    end
  end

  // write port selection
  always_comb begin
    kp_we = 1'b0;
    kp_wa = cur;
    k_wd  = key_r;
    p_wd  = pay_r;
    pv_we = 1'b0;
    pv_wa = cur;
    pv_wd = NoLink;
    nx_we = 1'b0;
    nx_wa = cur;
    nx_wd = NoLink;
    unique case (cmd.wr)
      WR_NONE: begin
      end
      WR_HOME: begin
        kp_we = 1'b1;
        pv_we = 1'b1;
        nx_we = 1'b1;
      end
      WR_TAIL: begin
        kp_we = 1'b1;
        kp_wa = r;
        pv_we = 1'b1;
        pv_wa = r;
        pv_wd = LW'(cur);
        nx_we = 1'b1;
        nx_wa = r;
      end
      WR_LINK: begin
        nx_we = 1'b1;
        nx_wd = LW'(r);
      end
      WR_MOVE: begin
        kp_we = 1'b1;
        kp_wa = r;
        k_wd  = hkey;
        p_wd  = hpay;
        pv_we = 1'b1;
        pv_wa = r;
        pv_wd = hprev;
        nx_we = 1'b1;
        nx_wa = r;
        nx_wd = hnext;
      end
      WR_RELINK: begin
        nx_we = (hprev < NoLink);
        nx_wa = hprev[IW-1:0];
        nx_wd = LW'(r);
        pv_we = (hnext < NoLink);
        pv_wa = hnext[IW-1:0];
        pv_wd = LW'(r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (kp_we) begin
      key_mem[kp_wa] <= k_wd;
      pay_mem[kp_wa] <= p_wd;
    end
    rd_key <= key_mem[cur];
    rd_pay <= pay_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (pv_we) begin
      prev_mem[pv_wa] <= pv_wd;
    end
    rd_prev <= prev_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      next_mem[nx_wa] <= nx_wd;
    end
    rd_next <= next_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      unique case (cmd.wr)
        WR_HOME:           used[cur] <= 1'b1;
        WR_TAIL, WR_MOVE:  used[r]   <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      slot_used        <= 1'b0;
      slot_key_out     <= '0;
      slot_payload_out <= '0;
      prev_link        <= '0;
      next_link        <= '0;
      unique case (cmd.res)
        RES_READ: begin
          status     <= ST_READ;
          slot_index <= IDX_W'(cur);
          slot_used  <= rd_used;
          if (rd_used) begin
            slot_key_out     <= rd_key;
            slot_payload_out <= rd_pay;
            prev_link        <= LINK_W'(rd_prev);
            next_link        <= LINK_W'(rd_next);
          end else begin
            prev_link <= LINK_W'(NoLink);
            next_link <= LINK_W'(NoLink);
          end
        end
        RES_HOME: begin
          status     <= ST_INSERTED;
          slot_index <= IDX_W'(cur);
        end
        RES_PROBE: begin
          status     <= ST_INSERTED;
          slot_index <= IDX_W'(r);
        end
        RES_FULL: begin
          status     <= ST_FULL;
          slot_index <= '0;
        end
        default: begin
          status     <= ST_FULL;
          slot_index <= '0;
        end
      endcase
    end
  end

endmodule

FILE: rtl/hic_ctrl.sv
// controller: sequences hashing, chain walk, probing and slot writes
`include "hash_insert_chaining_with_replace_unit_assert.svh"

module hic_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           action,
  output logic           out_valid,
  input  logic           out_stall,
  output hic_pkg::cmd_t  cmd,
  input  hic_pkg::sts_t  sts
);
  import hic_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.res_load || (out_valid && out_stall);
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    cmd.wr     = WR_NONE;
    cmd.res    = RES_READ;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (action == ACT_READ) ? S_FETCH : S_HASH_NEW;
        end
      end
      S_HASH_NEW: begin
        cmd.hash_start = 1'b1;
        state_next     = S_HASH_NEW_WAIT;
      end
      S_HASH_NEW_WAIT: begin
        if (!sts.hash_busy) begin
          cmd.cur_from_hash = 1'b1;
          state_next        = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        priority if (sts.is_read) begin
          state_next = S_DONE_READ;
        end else if (!sts.home_used) begin
          cmd.wr     = WR_HOME;
          state_next = S_DONE_HOME;
        end else begin
          cmd.hold   = 1'b1;
          state_next = S_HASH_OLD;
        end
      end
      S_HASH_OLD: begin
        cmd.hash_start = 1'b1;
        cmd.hash_held  = 1'b1;
        state_next     = S_HASH_OLD_WAIT;
      end
      S_HASH_OLD_WAIT: begin
        if (!sts.hash_busy) begin
          if (sts.home_match) begin
            cmd.walk_init = 1'b1;
            state_next    = S_WALK;
          end else begin
            cmd.probe_init = 1'b1;
            state_next     = S_PROBE_EV;
          end
        end
      end
      S_WALK: begin
        if (sts.walk_more) begin
          cmd.walk_step = 1'b1;
          state_next    = S_WALK_WAIT;
        end else begin
          cmd.probe_init = 1'b1;
          state_next     = S_PROBE_CH;
        end
      end
      S_WALK_WAIT: begin
        state_next = S_WALK;
      end
      S_PROBE_CH: begin
        priority if (sts.probe_free) begin
          state_next = S_CH_WRITE;
        end else if (sts.probe_last) begin
          state_next = S_DONE_FULL;
        end else begin
          cmd.probe_step = 1'b1;
        end
      end
      S_CH_WRITE: begin
        cmd.wr     = WR_TAIL;
        state_next = S_CH_LINK;
      end
      S_CH_LINK: begin
        cmd.wr     = WR_LINK;
        state_next = S_DONE_PROBE;
      end
      S_PROBE_EV: begin
        priority if (sts.probe_free) begin
          state_next = S_EV_MOVE;
        end else if (sts.probe_last) begin
          state_next = S_DONE_FULL;
        end else begin
          cmd.probe_step = 1'b1;
        end
      end
      S_EV_MOVE: begin
        cmd.wr     = WR_MOVE;
        state_next = S_EV_RELINK;
      end
      S_EV_RELINK: begin
        cmd.wr     = WR_RELINK;
        state_next = S_EV_HOME;
      end
      S_EV_HOME: begin
        cmd.wr     = WR_HOME;
        state_next = S_DONE_HOME;
      end
      S_DONE_READ: begin
        cmd.res = RES_READ;
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DONE_HOME: begin
        cmd.res = RES_HOME;
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DONE_PROBE: begin
        cmd.res = RES_PROBE;
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DONE_FULL: begin
        cmd.res = RES_FULL;
        if (out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `HIC_ASSERT_NXT(a_result_shown, clk, rst, cmd.res_load, out_valid)
  `HIC_ASSERT_NXT(a_hash_running, clk, rst, cmd.hash_start, sts.hash_busy)
  `HIC_ASSERT_NXT(a_request_held, clk, rst, in_valid && !in_stall, state != S_IDLE)
  `HIC_ASSERT_IMP(a_no_load_blocked, clk, rst, cmd.res_load && out_valid, !out_stall)

endmodule

FILE: dv/tb_hash_insert_chaining_with_replace_unit.sv
// self-checking testbench for the chained hash table insert unit with home-slot replacement
module tb_hash_insert_chaining_with_replace_unit;
  import hic_pkg::*;

  localparam int NUM_SLOTS = SLOTS;
  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(NUM_SLOTS);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_REQS = 1200;

  typedef struct packed {
    logic             act;
    logic [KEY_W-1:0] rkey;
    logic [PAY_W-1:0] rpay;
    logic [IDX_W-1:0] rslot;
  } hash_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] stat;
    logic [IDX_W-1:0]  idx;
    logic              used;
    logic [KEY_W-1:0]  skey;
    logic [PAY_W-1:0]  spay;
    logic [LINK_W-1:0] prv;
    logic [LINK_W-1:0] nxt;
  } hash_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_INSERT;
  logic [KEY_W-1:0] key = '0;
  logic [PAY_W-1:0] payload = '0;
  logic [IDX_W-1:0] read_slot = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0] slot_index;
  logic slot_used;
  logic [KEY_W-1:0] slot_key_out;
  logic [PAY_W-1:0] slot_payload_out;
  logic [LINK_W-1:0] prev_link;
  logic [LINK_W-1:0] next_link;

  hash_req_t request_q[$];
  hash_result_t hash_results_q[$];

  logic tbl_used[NUM_SLOTS];
  logic [KEY_W-1:0] tbl_key[NUM_SLOTS];
  logic [PAY_W-1:0] tbl_pay[NUM_SLOTS];
  logic [LINK_W-1:0] tbl_prev[NUM_SLOTS];
  logic [LINK_W-1:0] tbl_next[NUM_SLOTS];

  int err_cnt = 0;
  int cycle_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  hash_insert_chaining_with_replace_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .key(key),
    .payload(payload),
    .read_slot(read_slot),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .slot_index(slot_index),
    .slot_used(slot_used),
    .slot_key_out(slot_key_out),
    .slot_payload_out(slot_payload_out),
    .prev_link(prev_link),
    .next_link(next_link)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned free_after(input int unsigned start);
    int unsigned r;
    r = start;
    for (int n = 0; n + 1 < NUM_SLOTS; n++) begin
      r = (r + 1) % NUM_SLOTS;
      if (!tbl_used[r]) return r;
    end
    return NUM_SLOTS;
  endfunction

  task automatic store_entry(input int unsigned s, input logic [KEY_W-1:0] k,
                             input logic [PAY_W-1:0] pay, input logic [LINK_W-1:0] p,
                             input logic [LINK_W-1:0] nx);
    tbl_used[s] = 1'b1;
    tbl_key[s] = k;
    tbl_pay[s] = pay;
    tbl_prev[s] = p;
    tbl_next[s] = nx;
  endtask

  task automatic apply_to_table(input logic act, input logic [KEY_W-1:0] k,
                                input logic [PAY_W-1:0] pay, input logic [IDX_W-1:0] rs);
    hash_result_t res;
    int unsigned home, tail, steps, spot;
    logic [LINK_W-1:0] p, nx;
    res = '0;
    res.stat = ST_INSERTED;
    if (act == ACT_READ) begin
      res.stat = ST_READ;
      res.idx = rs;
      res.prv = NO_LINK;
      res.nxt = NO_LINK;
      if (tbl_used[rs]) begin
        res.used = 1'b1;
        res.skey = tbl_key[rs];
        res.spay = tbl_pay[rs];
        res.prv = tbl_prev[rs];
        res.nxt = tbl_next[rs];
      end
    end else begin
      home = k % NUM_SLOTS;
      if (!tbl_used[home]) begin
        store_entry(home, k, pay, NO_LINK, NO_LINK);
        res.idx = IDX_W'(home);
      end else if (tbl_key[home] % NUM_SLOTS == home) begin
        tail = home;
        steps = 0;
        while (tbl_next[tail] < NUM_SLOTS && steps < NUM_SLOTS) begin
          tail = tbl_next[tail];
          steps++;
        end
        spot = free_after(tail);
        if (spot >= NUM_SLOTS) begin
          res.stat = ST_FULL;
        end else begin
          store_entry(spot, k, pay, LINK_W'(tail), NO_LINK);
          tbl_next[tail] = LINK_W'(spot);
          res.idx = IDX_W'(spot);
        end
      end else begin
        spot = free_after(home);
        if (spot >= NUM_SLOTS) begin
          res.stat = ST_FULL;
        end else begin
          // evict the foreign record and relink its chain neighbors
          p = tbl_prev[home];
          nx = tbl_next[home];
          store_entry(spot, tbl_key[home], tbl_pay[home], p, nx);
          if (p < NUM_SLOTS) tbl_next[p] = LINK_W'(spot);
          if (nx < NUM_SLOTS) tbl_prev[nx] = LINK_W'(spot);
          store_entry(home, k, pay, NO_LINK, NO_LINK);
          res.idx = IDX_W'(home);
        end
      end
    end
    hash_results_q.push_back(res);
  endtask

  task automatic chk_field(input string name, input logic [PAY_W-1:0] want,
                           input logic [PAY_W-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic push_req(input logic act, input logic [KEY_W-1:0] k,
                          input logic [PAY_W-1:0] pay, input logic [IDX_W-1:0] rs);
    hash_req_t r;
    r.act = act;
    r.rkey = k;
    r.rpay = pay;
    r.rslot = rs;
    request_q.push_back(r);
  endtask

  always @(posedge clk) begin : drive_proc
    hash_req_t req;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) apply_to_table(action, key, payload, read_slot);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          in_valid <= 1'b1;
          action <= req.act;
          key <= req.rkey;
          payload <= req.rpay;
          read_slot <= req.rslot;
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_proc
    hash_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (hash_results_q.size() == 0) begin
          err_cnt++;
          $display("%0t: result with none awaited, expected nothing actual status %0h slot %0h",
                   $time, status, slot_index);
        end else begin
          want = hash_results_q.pop_front();
          chk_field("status", want.stat, status);
          chk_field("slot_index", want.idx, slot_index);
          chk_field("slot_used", want.used, slot_used);
          chk_field("slot_key_out", want.skey, slot_key_out);
          chk_field("slot_payload_out", want.spay, slot_payload_out);
          chk_field("prev_link", want.prv, prev_link);
          chk_field("next_link", want.nxt, next_link);
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("** hash_insert_chaining_with_replace_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int filled, roll, s;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i] = '0;
      tbl_pay[i] = '0;
      tbl_prev[i] = NO_LINK;
      tbl_next[i] = NO_LINK;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // chain of three records on home 3
    push_req(ACT_INSERT, 32'h0000_0003, 64'h0, 4'h0);
    push_req(ACT_INSERT, 32'h0000_0013, 64'h5555_5555_5555_5555, 4'hf);
    push_req(ACT_INSERT, 32'h0000_0023, 64'haaaa_aaaa_aaaa_aaaa, 4'h0);
    // home 4 holds a chain member: evict it, both neighbors relinked
    push_req(ACT_INSERT, 32'hffff_fff4, 64'hffff_ffff_ffff_ffff, 4'hf);
    push_req(ACT_READ, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 4'h3);
    push_req(ACT_READ, 32'h0, 64'h0, 4'h4);
    push_req(ACT_READ, 32'h0, 64'h0, 4'h5);
    push_req(ACT_READ, 32'h0, 64'h0, 4'h6);
    // chain that wraps from the last slot to slot 0, then evict from slot 0
    push_req(ACT_INSERT, 32'hffff_ffff, 64'h0123_4567_89ab_cdef, 4'h0);
    push_req(ACT_INSERT, 32'h0000_000f, 64'hfedc_ba98_7654_3210, 4'h0);
    push_req(ACT_INSERT, 32'h0000_0000, 64'h8000_0000_0000_0001, 4'h0);
    push_req(ACT_READ, 32'h0, 64'h0, 4'h0);
    push_req(ACT_READ, 32'h0, 64'h0, 4'h1);
    push_req(ACT_READ, 32'h0, 64'h0, 4'hf);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      while (request_q.size() >= 2) @(negedge clk);
      if (n % 150 == 0) steady = ($urandom_range(0, 3) == 0);
      filled = 0;
      for (int i = 0; i < NUM_SLOTS; i++) if (tbl_used[i]) filled++;
      roll = $urandom_range(0, 99);
      if (filled != 0 && (filled < NUM_SLOTS ? roll < 25 : roll < 50)) begin
        s = $urandom_range(0, NUM_SLOTS - 1);
        while (!tbl_used[s]) s = (s + 1) % NUM_SLOTS;
        push_req(ACT_READ, $urandom(), {$urandom(), $urandom()}, IDX_W'(s));
      end else begin
        k = $urandom();
        if ($urandom_range(0, 4) != 0) k[3:0] = 4'($urandom_range(0, 3) * 5);
        push_req(ACT_INSERT, k, {$urandom(), $urandom()}, IDX_W'($urandom_range(0, 15)));
      end
    end

    while (request_q.size() != 0 || in_valid) @(negedge clk);
    while (hash_results_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (err_cnt == 0) begin
      $display("** hash_insert_chaining_with_replace_unit: PASSED **");
    end else begin
      $display("** hash_insert_chaining_with_replace_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/hic_pkg.sv
rtl/hic_mod.sv
rtl/hic_dp.sv
rtl/hic_ctrl.sv
rtl/hash_insert_chaining_with_replace_unit.sv
dv/tb_hash_insert_chaining_with_replace_unit.sv
